@@ hdl/overhead_light_run_controller_assert.svh @@
// assertion helpers shared by the controller rtl
`ifndef OVERHEAD_LIGHT_RUN_CONTROLLER_ASSERT_SVH
`define OVERHEAD_LIGHT_RUN_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OLRC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olrc assertion failed");

// next-cycle implication, disabled during reset
`define OLRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olrc assertion failed");

`endif

@@ hdl/olrc_pkg.sv @@
`default_nettype none
package olrc_pkg;

   localparam int unsigned TIME_WIDTH   = 32;
   localparam int unsigned LIGHT_WIDTH  = 10;
   localparam int unsigned TICKS_WIDTH  = 16;
   localparam int unsigned DUTY_WIDTH   = 16;
   localparam int unsigned CSR_IDX_WIDTH  = 3;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   // register indexes on the csr port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LIGHT_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STARTUP_TICKS   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RUN_TICKS       = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RESUME_DELAY    = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FULL_DUTY       = 3'd4;

   // reset values of the registers
   localparam logic [LIGHT_WIDTH-1:0] LIGHT_THRESHOLD_RESET = 10'd255;
   localparam logic [TICKS_WIDTH-1:0] STARTUP_TICKS_RESET   = 16'd76;
   localparam logic [TICKS_WIDTH-1:0] RUN_TICKS_RESET       = 16'd1140;
   localparam logic [TICKS_WIDTH-1:0] RESUME_DELAY_RESET    = 16'd15;
   localparam logic [DUTY_WIDTH-1:0]  FULL_DUTY_RESET       = 16'd19660;

   // mode codes as reported on the result channel
   localparam logic [1:0] MODE_CODE_WAIT    = 2'd0;
   localparam logic [1:0] MODE_CODE_STARTUP = 2'd1;
   localparam logic [1:0] MODE_CODE_RUN     = 2'd2;
   localparam logic [1:0] MODE_CODE_UNUSED  = 2'd3;

   typedef enum logic [2:0] {
      MODE_WAIT    = 3'b001,
      MODE_STARTUP = 3'b010,
      MODE_RUN     = 3'b100
   } mode_type;

   function automatic logic [1:0] mode_code(input mode_type mode);
      logic [1:0] code;
      case (mode)
         MODE_WAIT:    code = MODE_CODE_WAIT;
         MODE_STARTUP: code = MODE_CODE_STARTUP;
         MODE_RUN:     code = MODE_CODE_RUN;
         default:      code = MODE_CODE_UNUSED;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

@@ hdl/overhead_light_run_controller.sv @@
// Overhead light run controller.
// req channel: one transaction per sensor sample (tick time, front and rear
// light readings), valid/ready. rsp channel: one transaction per request with
// mode, speed state, motor duty, duty update flag, emitter and standby LED.
// A request accepted at an edge has its response valid after that edge. The
// rate is one transaction per cycle without stalls, set by the single
// registered pass through the mode logic (three 32-bit add and compare paths).
// The response fields are read straight from the controller state, which only
// moves when a request is accepted; req_ready is high while the response slot
// is empty or being taken, so a stalled receiver holds the response and back-
// pressures the request side without losing anything.
// csr port: a write with csr_write high lands at the clock edge; index 0 light
// threshold, 1 startup ticks, 2 run ticks, 3 resume delay, 4 full duty; other
// indexes are ignored. Write only while idle.
// Reset (synchronous, active high) puts the block in waiting mode, motors
// stopped, duty zero, emitter and standby LED off, registers to defaults, and
// empties the response slot.
`default_nettype none
`include "overhead_light_run_controller_assert.svh"
module overhead_light_run_controller (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [olrc_pkg::TIME_WIDTH-1:0]       req_now,
   input  wire logic [olrc_pkg::LIGHT_WIDTH-1:0]      req_front_light,
   input  wire logic [olrc_pkg::LIGHT_WIDTH-1:0]      req_rear_light,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [1:0]                                 rsp_mode,
   output logic                                       rsp_full_speed,
   output logic [olrc_pkg::DUTY_WIDTH-1:0]            rsp_drive_duty,
   output logic                                       rsp_duty_update,
   output logic                                       rsp_emitter_on,
   output logic                                       rsp_standby_led,
   input  wire logic                                  csr_write,
   input  wire logic [olrc_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [olrc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   // configuration
   logic [olrc_pkg::LIGHT_WIDTH-1:0] threshold_ff;
   logic [olrc_pkg::TICKS_WIDTH-1:0] startup_ticks_ff;
   logic [olrc_pkg::TICKS_WIDTH-1:0] run_ticks_ff;
   logic [olrc_pkg::TICKS_WIDTH-1:0] resume_delay_ff;
   logic [olrc_pkg::DUTY_WIDTH-1:0]  full_duty_ff;

   // controller state
   olrc_pkg::mode_type               mode_ff, mode_in;
   logic                             speed_ff, speed_in;
   logic [olrc_pkg::TIME_WIDTH-1:0]  startup_start_ff, startup_start_in;
   logic [olrc_pkg::TIME_WIDTH-1:0]  run_start_ff, run_start_in;
   logic [olrc_pkg::TIME_WIDTH-1:0]  last_seen_ff, last_seen_in;
   logic [olrc_pkg::DUTY_WIDTH-1:0]  duty_ff, duty_in;
   logic                             emitter_ff, emitter_in;
   logic                             standby_ff, standby_in;

   // response slot
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             duty_update_ff, duty_update_in;

   logic                             accept;
   logic                             light_seen;
   logic [olrc_pkg::TIME_WIDTH-1:0]  startup_end;
   logic [olrc_pkg::TIME_WIDTH-1:0]  run_end;
   logic [olrc_pkg::TIME_WIDTH-1:0]  resume_end;
   logic                             startup_done;
   logic                             run_done;
   logic                             resume_done;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign light_seen = (req_front_light > threshold_ff) || (req_rear_light > threshold_ff);

   // end times wrap modulo 2^32
   assign startup_end = startup_start_ff
                      + {{(olrc_pkg::TIME_WIDTH-olrc_pkg::TICKS_WIDTH){1'b0}}, startup_ticks_ff};
   assign run_end     = run_start_ff
                      + {{(olrc_pkg::TIME_WIDTH-olrc_pkg::TICKS_WIDTH){1'b0}}, run_ticks_ff};
   assign resume_end  = last_seen_ff
                      + {{(olrc_pkg::TIME_WIDTH-olrc_pkg::TICKS_WIDTH){1'b0}}, resume_delay_ff};

   assign startup_done = req_now > startup_end;
   assign run_done     = req_now > run_end;
   assign resume_done  = req_now > resume_end;

   always_comb begin
      mode_in          = mode_ff;
      speed_in         = speed_ff;
      startup_start_in = startup_start_ff;
      run_start_in     = run_start_ff;
      last_seen_in     = last_seen_ff;
      emitter_in       = emitter_ff;
      standby_in       = standby_ff;
      case (mode_ff)
         olrc_pkg::MODE_WAIT: begin
            emitter_in = 1'b0;
            standby_in = 1'b1;
            speed_in   = 1'b0;
            if (light_seen) begin
               emitter_in       = 1'b1;
               standby_in       = 1'b0;
               mode_in          = olrc_pkg::MODE_STARTUP;
               startup_start_in = req_now;
            end
         end
         olrc_pkg::MODE_STARTUP: begin
            speed_in = 1'b1;
            if (startup_done) begin
               mode_in      = olrc_pkg::MODE_RUN;
               run_start_in = req_now;
            end
         end
         olrc_pkg::MODE_RUN: begin
            if (light_seen) begin
               last_seen_in = req_now;
               speed_in     = 1'b0;
            end else if (!speed_ff && resume_done) begin
               speed_in = 1'b1;
            end
            // speed is left as is on the way back to waiting
            if (run_done) begin
               mode_in = olrc_pkg::MODE_WAIT;
            end
         end
         default: begin
         end
      endcase
      duty_update_in = speed_in != speed_ff;
      duty_in        = duty_ff;
      if (duty_update_in) begin
         duty_in = speed_in ? full_duty_ff : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff     <= olrc_pkg::LIGHT_THRESHOLD_RESET;
         startup_ticks_ff <= olrc_pkg::STARTUP_TICKS_RESET;
         run_ticks_ff     <= olrc_pkg::RUN_TICKS_RESET;
         resume_delay_ff  <= olrc_pkg::RESUME_DELAY_RESET;
         full_duty_ff     <= olrc_pkg::FULL_DUTY_RESET;
      end else if (csr_write) begin
         case (csr_index)
            olrc_pkg::CSR_LIGHT_THRESHOLD: threshold_ff     <= csr_data[olrc_pkg::LIGHT_WIDTH-1:0];
            olrc_pkg::CSR_STARTUP_TICKS:   startup_ticks_ff <= csr_data;
            olrc_pkg::CSR_RUN_TICKS:       run_ticks_ff     <= csr_data;
            olrc_pkg::CSR_RESUME_DELAY:    resume_delay_ff  <= csr_data;
            olrc_pkg::CSR_FULL_DUTY:       full_duty_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= olrc_pkg::MODE_WAIT;
         speed_ff         <= 1'b0;
         startup_start_ff <= '0;
         run_start_ff     <= '0;
         last_seen_ff     <= '0;
         duty_ff          <= '0;
         emitter_ff       <= 1'b0;
         standby_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff          <= mode_in;
            speed_ff         <= speed_in;
            startup_start_ff <= startup_start_in;
            run_start_ff     <= run_start_in;
            last_seen_ff     <= last_seen_in;
            duty_ff          <= duty_in;
            emitter_ff       <= emitter_in;
            standby_ff       <= standby_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         duty_update_ff <= duty_update_in;
      end
   end

   // state only moves on acceptance, so it is the pending response
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mode        = olrc_pkg::mode_code(mode_ff);
   assign rsp_full_speed  = speed_ff;
   assign rsp_drive_duty  = duty_ff;
   assign rsp_duty_update = duty_update_ff;
   assign rsp_emitter_on  = emitter_ff;
   assign rsp_standby_led = standby_ff;

   `OLRC_ASSERT_SAME(a_standby_only_waiting, clock, reset,
      rsp_valid && rsp_standby_led, rsp_mode == olrc_pkg::MODE_CODE_WAIT)
   `OLRC_ASSERT_SAME(a_emitter_standby_excl, clock, reset,
      1'b1, !(emitter_ff && standby_ff))
   `OLRC_ASSERT_NEXT(a_startup_full_speed, clock, reset,
      accept && mode_ff == olrc_pkg::MODE_STARTUP, speed_ff)
   `OLRC_ASSERT_NEXT(a_update_tracks_speed, clock, reset,
      accept, rsp_duty_update == (speed_ff != $past(speed_ff)))

endmodule
`default_nettype wire
